// File: rtl/binary_lifting_lca_engine_defines.svh
// assertion macros shared by the lowest common ancestor engine checker
// no dependencies; included by the checker file only
`ifndef BINARY_LIFTING_LCA_ENGINE_DEFINES_SVH
`define BINARY_LIFTING_LCA_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BLL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bll_pkg.sv
// shared types and constants of the lowest common ancestor engine
// no dependencies; imported by controller, datapath, top level and checker
`default_nettype none

package bll_pkg;

  // field widths of the stream payloads
  localparam int NODE_FW     = 16;
  localparam int DEP_W       = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic [DEP_W-1:0] DEP_MAX = '1;

  // request kinds carried on in_tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // depth memory read address source
  localparam logic [1:0] DSEL_A   = 2'd0;
  localparam logic [1:0] DSEL_B   = 2'd1;
  localparam logic [1:0] DSEL_ANC = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;     // latch request nodes
    logic [1:0] dsel;     // depth read address source
    logic       asel;     // ancestor port a reads the mid node instead of a
    logic       ins_base; // write depth and level zero of the new node
    logic       ins_lvl;  // write the current level of the new node
    logic       cap_da;   // capture depth of a
    logic       cap_db;   // capture depth of b and order the pair
    logic       jump;     // a takes its ancestor at the current level
    logic       pair;     // lift both nodes where their ancestors differ
    logic       up0;      // a takes its parent
    logic       lvl_top;
    logic       lvl_one;
    logic       lvl_dec;
    logic       lvl_inc;
    logic       out_load; // present a as the answer
  } ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_query;  // pending request is a query
    logic in_void;   // pending insert names node zero
    logic jump_ok;   // depth gap covers the current level
    logic lvl_zero;
    logic lvl_last;
    logic a_eq_b;
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/bll_datapath.sv
// ancestor and depth memories, node and depth registers, output register
// depends on bll_pkg; driven by bll_ctrl through ctl_t
`default_nettype none

module bll_datapath import bll_pkg::*; #(
  parameter int MAX_NODES = 65535,
  parameter int LEVELS    = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [0:0]             in_tuser,
  input  wire ctl_t                   ctl,
  output sts_t                        sts,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int NW        = $clog2(MAX_NODES + 1);
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_DEPTH = (MAX_NODES + 1) << LW;
  localparam int DEP_DEPTH = MAX_NODES + 1;
  localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

  // ids above the node range count as node zero
  function automatic logic [NW-1:0] node_of(input logic [NODE_FW-1:0] raw);
    return (raw > NODE_FW'(MAX_NODES)) ? '0 : raw[NW-1:0];
  endfunction

  logic [NW-1:0]    anc_mem [ANC_DEPTH];
  logic [DEP_W-1:0] dep_mem [DEP_DEPTH];

  logic [NW-1:0]    a_r, b_r, mid_r;
  logic [DEP_W-1:0] da_r, db_r;
  logic [LW-1:0]    level_r;
  logic [NW-1:0]    anc_qa_r, anc_qb_r;
  logic             za_r, zb_r;
  logic [DEP_W-1:0] dep_q_r;
  logic             dz_r;
  logic             out_valid_r;
  logic [NW-1:0]    out_node_r;

  logic [NW-1:0]    in_first, in_second;
  logic [NW-1:0]    anc_a_val, anc_b_val;
  logic [DEP_W-1:0] dep_val, dep_wd;
  logic [NW+LW-1:0] anc_ra, anc_rb, anc_wa;
  logic [NW-1:0]    anc_wd, dep_ra;
  logic             anc_we;
  logic [DEP_W-1:0] gap;
  logic [DEP_W:0]   span;

  assign in_first  = node_of(in_tdata[NODE_FW-1:0]);
  assign in_second = node_of(in_tdata[2*NODE_FW-1:NODE_FW]);

  // node zero reads as no ancestor and depth zero
  assign anc_a_val = za_r ? '0 : anc_qa_r;
  assign anc_b_val = zb_r ? '0 : anc_qb_r;
  assign dep_val   = dz_r ? '0 : dep_q_r;

  // memory addresses, the mid node is read one level below the one being filled
  assign anc_ra = ctl.asel ? {mid_r, level_r - LW'(1)} : {a_r, level_r};
  assign anc_rb = {b_r, level_r};

  always_comb begin
    unique case (ctl.dsel)
      DSEL_A:   dep_ra = a_r;
      DSEL_B:   dep_ra = b_r;
      DSEL_ANC: dep_ra = anc_a_val;
      default:  dep_ra = a_r;
    endcase
  end

  assign anc_we = ctl.ins_base | ctl.ins_lvl;
  assign anc_wa = {a_r, (ctl.ins_base ? LW'(0) : level_r)};
  assign anc_wd = ctl.ins_base ? b_r : anc_a_val;
  assign dep_wd = (dep_val == DEP_MAX) ? DEP_MAX : dep_val + DEP_W'(1);

  // memories, registered read data
  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[anc_wa] <= anc_wd;
    end
    if (ctl.ins_base) begin
      dep_mem[a_r] <= dep_wd;
    end
    anc_qa_r <= anc_mem[anc_ra];
    anc_qb_r <= anc_mem[anc_rb];
    dep_q_r  <= dep_mem[dep_ra];
    za_r     <= (anc_ra[NW+LW-1:LW] == '0);
    zb_r     <= (b_r == '0);
    dz_r     <= (dep_ra == '0);
  end

  // node registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= in_first;
      b_r <= in_second;
    end else if (ctl.cap_db && (da_r < dep_val)) begin
      a_r <= b_r;
      b_r <= a_r;
    end else if (ctl.jump || ctl.up0) begin
      a_r <= anc_a_val;
    end else if (ctl.pair && (anc_a_val != anc_b_val)) begin
      a_r <= anc_a_val;
      b_r <= anc_b_val;
    end
    if (ctl.ins_base) begin
      mid_r <= b_r;
    end else if (ctl.ins_lvl) begin
      mid_r <= anc_a_val;
    end
  end

  // depth registers, the deeper node ends up in a
  always_ff @(posedge clk) begin
    if (ctl.cap_da) begin
      da_r <= dep_val;
    end else if (ctl.cap_db) begin
      if (da_r < dep_val) begin
        da_r <= dep_val;
        db_r <= da_r;
      end else begin
        db_r <= dep_val;
      end
    end
  end

  // lifting level counter
  always_ff @(posedge clk) begin
    priority if (ctl.lvl_top) begin
      level_r <= LVL_LAST;
    end else if (ctl.lvl_one) begin
      level_r <= LW'(1);
    end else if (ctl.lvl_dec) begin
      level_r <= level_r - LW'(1);
    end else if (ctl.lvl_inc) begin
      level_r <= level_r + LW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_node_r <= a_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_node_r);

  // status towards the controller
  assign gap  = da_r - db_r;
  assign span = (DEP_W + 1)'(1) << level_r;

  assign sts.in_query = (in_tuser[0] == CMD_QUERY);
  assign sts.in_void  = (in_first == '0);
  assign sts.jump_ok  = (da_r >= db_r) && ({1'b0, gap} >= span);
  assign sts.lvl_zero = (level_r == '0);
  assign sts.lvl_last = (level_r == LVL_LAST);
  assign sts.a_eq_b   = (a_r == b_r);
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

// File: rtl/bll_ctrl.sv
// sequencer for inserts and queries of the lowest common ancestor engine
// depends on bll_pkg; drives bll_datapath through ctl_t
`default_nettype none

module bll_ctrl import bll_pkg::*; #(
  parameter int LEVELS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INS_RD  = 5'd1;
  localparam logic [4:0] S_INS_WR  = 5'd2;
  localparam logic [4:0] S_INS_LRD = 5'd3;
  localparam logic [4:0] S_INS_LWR = 5'd4;
  localparam logic [4:0] S_Q_DA    = 5'd5;
  localparam logic [4:0] S_Q_DB    = 5'd6;
  localparam logic [4:0] S_Q_SW    = 5'd7;
  localparam logic [4:0] S_Q_L1    = 5'd8;
  localparam logic [4:0] S_Q_L1A   = 5'd9;
  localparam logic [4:0] S_Q_L1E   = 5'd10;
  localparam logic [4:0] S_Q_CMP   = 5'd11;
  localparam logic [4:0] S_Q_L2    = 5'd12;
  localparam logic [4:0] S_Q_L2C   = 5'd13;
  localparam logic [4:0] S_Q_UP    = 5'd14;
  localparam logic [4:0] S_Q_UPC   = 5'd15;
  localparam logic [4:0] S_Q_OUT   = 5'd16;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    ctl       = '0;
    ctl.dsel  = DSEL_A;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load = 1'b1;
          priority if (sts.in_query) begin
            state_nxt = S_Q_DA;
          end else if (sts.in_void) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_INS_RD;
          end
        end
      end
      // insert: parent depth, then a read state and a write state for each level
      S_INS_RD: begin
        ctl.dsel  = DSEL_B;
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        ctl.ins_base = 1'b1;
        ctl.lvl_one  = 1'b1;
        state_nxt    = (LEVELS == 1) ? S_IDLE : S_INS_LRD;
      end
      S_INS_LRD: begin
        ctl.asel  = 1'b1;
        state_nxt = S_INS_LWR;
      end
      S_INS_LWR: begin
        ctl.ins_lvl = 1'b1;
        if (sts.lvl_last) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.lvl_inc = 1'b1;
          state_nxt   = S_INS_LRD;
        end
      end
      // query: read both depths and order the pair
      S_Q_DA: begin
        ctl.dsel  = DSEL_A;
        state_nxt = S_Q_DB;
      end
      S_Q_DB: begin
        ctl.dsel   = DSEL_B;
        ctl.cap_da = 1'b1;
        state_nxt  = S_Q_SW;
      end
      S_Q_SW: begin
        ctl.cap_db  = 1'b1;
        ctl.lvl_top = 1'b1;
        state_nxt   = S_Q_L1;
      end
      // lift the deeper node to equal depth
      S_Q_L1: begin
        priority if (sts.jump_ok) begin
          state_nxt = S_Q_L1A;
        end else if (sts.lvl_zero) begin
          state_nxt = S_Q_CMP;
        end else begin
          ctl.lvl_dec = 1'b1;
        end
      end
      S_Q_L1A: begin
        ctl.jump  = 1'b1;
        ctl.dsel  = DSEL_ANC;
        state_nxt = S_Q_L1E;
      end
      S_Q_L1E: begin
        ctl.cap_da = 1'b1;
        if (sts.lvl_zero) begin
          state_nxt = S_Q_CMP;
        end else begin
          ctl.lvl_dec = 1'b1;
          state_nxt   = S_Q_L1;
        end
      end
      S_Q_CMP: begin
        if (sts.a_eq_b) begin
          state_nxt = S_Q_OUT;
        end else begin
          ctl.lvl_top = 1'b1;
          state_nxt   = S_Q_L2;
        end
      end
      // lift both while their ancestors differ
      S_Q_L2: begin
        state_nxt = S_Q_L2C;
      end
      S_Q_L2C: begin
        ctl.pair = 1'b1;
        if (sts.lvl_zero) begin
          state_nxt = S_Q_UP;
        end else begin
          ctl.lvl_dec = 1'b1;
          state_nxt   = S_Q_L2;
        end
      end
      S_Q_UP: begin
        state_nxt = S_Q_UPC;
      end
      S_Q_UPC: begin
        ctl.up0   = 1'b1;
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/binary_lifting_lca_engine.sv
// top level of the lowest common ancestor engine (binary lifting)
// depends on bll_pkg, bll_ctrl and bll_datapath
//
// Usage: requests arrive on the in_ stream. in_tuser selects insert or query.
// An insert stores a node under its parent (parent 0 makes a root); parents
// must be inserted before their children. An insert gives no result. A query
// gives one result on the out_ stream: the lowest common ancestor id.
// Timing: one request at a time. An insert reads the parent depth and writes
// level zero, then takes a read state and a write state per level. A query is
// quickest when the lifted nodes meet at once; each level of the equal-depth
// lift needs an ancestor read and a depth read in turn.
// The result sits in an output register; a new request can be accepted while
// it waits. A stalled receiver holds out_tdata; a query that finishes while
// the previous result is still waiting stalls in its last step.
// Reset clears the sequencer and output valid only; the tables are not
// cleared and every queried node must have been inserted since reset.
`default_nettype none

module binary_lifting_lca_engine import bll_pkg::*; #(
  parameter int MAX_NODES = 65535,
  parameter int LEVELS    = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // first_node [15:0], second_node [31:16]
  input  wire logic [0:0]             in_tuser,  // cmd [0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata  // ancestor [15:0]
);

  ctl_t ctl;
  sts_t sts;

  // sequencer
  bll_ctrl #(
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // tables and working registers
  bll_datapath #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/bll_checker.sv
// port-level checks of the lowest common ancestor engine, bound to the top
// depends on bll_pkg and binary_lifting_lca_engine_defines.svh
`default_nettype none
`include "binary_lifting_lca_engine_defines.svh"

module bll_checker import bll_pkg::*; #(
  parameter int MAX_NODES = 65535
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic [0:0]             in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // a waiting result holds until taken
  `BLL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // a query keeps the block busy after acceptance
  `BLL_ASSERT_NEXT(a_query_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser[0] == CMD_QUERY), !in_tready, "request taken during a query")

  // an insert of a real node keeps the block busy after acceptance
  `BLL_ASSERT_NEXT(a_insert_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser[0] == CMD_INSERT) && (in_tdata[NODE_FW-1:0] != '0) && (in_tdata[NODE_FW-1:0] <= NODE_FW'(MAX_NODES)), !in_tready, "request taken during an insert")

  // a result only appears at the end of a query
  `BLL_ASSERT_NOW(a_out_from_query, clk, rst_n, $rose(out_tvalid), $past(!in_tready), "result without a query in progress")

endmodule

bind binary_lifting_lca_engine bll_checker #(
  .MAX_NODES (MAX_NODES)
) u_bll_checker (.*);

`default_nettype wire
